// ----- rtl/b3le_pkg.sv -----
package b3le_pkg;

    localparam int TABLE_WORDS = 8;
    localparam int TABLE_SIZE  = 512;
    localparam int LIT_W       = 17;

    localparam logic [LIT_W-1:0] LIT_CAP    = 17'h1FFFF;
    localparam logic [8:0]       SHIFT_KEEP = 9'h1B6;

    // Window indexes of one accepted pixel, handed to the result stage
    typedef struct packed {
        logic [8:0] idx0;
        logic [8:0] idx1;
        logic [8:0] idx2;
        logic       row_end;
        logic       frame_end;
    } win_t;

    // Slide the 3x3 window one column left and bring in a new column
    function automatic logic [8:0] win_shift(logic [8:0] w, logic t, logic m, logic b);
        logic [8:0] s;
        s = (w << 1) & SHIFT_KEEP;
        s[6] = s[6] | t;
        s[3] = s[3] | m;
        s[0] = s[0] | b;
        return s;
    endfunction

endpackage

// ----- rtl/b3le_line_buf.sv -----
module b3le_line_buf #(
    parameter int MAX_WIDTH = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               opcode,
    input  logic               pixel,
    input  logic               end_of_row,
    input  logic               last,
    input  logic               tbl_first,
    input  logic               tbl_final,
    output logic               win_valid,
    input  logic               win_ready,
    output b3le_pkg::win_t     win
);

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam logic [CW-1:0] COL_MAX = CW'(MAX_WIDTH);

    // front-end state
    logic [CW-1:0] col_reg, col_next;
    logic [CW-1:0] fw_reg, fw_next;
    logic [1:0]    rows_reg, rows_next;
    logic          par_reg, par_next;
    logic          bg_reg, bg_next;

    // second stage
    logic          b_valid_reg, b_valid_next;
    logic          b_v_reg, b_endr_reg, b_last_reg, b_bg_reg, b_col0_reg;
    logic          b_top_ok_reg, b_mid_ok_reg, b_par_reg, b_store_reg;
    logic [AW-1:0] b_addr_reg;
    logic [8:0]    window_reg, window_next;

    // line store: bit n of each word is bank n at that column
    logic [1:0]    mem [MAX_WIDTH];
    logic [1:0]    rdata_reg;
    logic          fwd_reg;
    logic [1:0]    fwd_word_reg;

    logic          acc, adv_b, wen;
    logic          v, endr, store, in_frame;
    logic [CW-1:0] col_inc;
    logic [AW-1:0] addr;
    logic [1:0]    word, wword;
    logic          top, mid;
    logic [8:0]    base, w1, w2, w3;

    assign adv_b    = b_valid_reg && win_ready;
    assign in_ready = !b_valid_reg || win_ready;
    assign acc      = in_valid && in_ready;

    assign v        = opcode ? bg_reg : pixel;
    assign endr     = end_of_row || last;
    assign store    = col_reg < COL_MAX;
    assign in_frame = store && (col_reg < fw_reg);
    assign col_inc  = store ? col_reg + CW'(1) : col_reg;
    assign addr     = col_reg[AW-1:0];

    always_comb
    begin
        col_next  = col_reg;
        fw_next   = fw_reg;
        rows_next = rows_reg;
        par_next  = par_reg;
        bg_next   = bg_reg;
        if (acc)
        begin
            col_next = endr ? '0 : col_inc;
            if (endr)
            begin
                if (rows_reg == 2'd0)
                begin
                    fw_next = col_inc;
                end
                rows_next = (rows_reg == 2'd2) ? 2'd2 : rows_reg + 2'd1;
                par_next  = !par_reg;
            end
            if (last)
            begin
                fw_next   = '0;
                rows_next = 2'd0;
                par_next  = 1'b0;
                bg_next   = bg_reg ? tbl_final : tbl_first;
            end
        end
    end

    always_comb
    begin
        b_valid_next = b_valid_reg;
        if (acc)
        begin
            b_valid_next = 1'b1;
        end
        else if (adv_b)
        begin
            b_valid_next = 1'b0;
        end
    end

    // read-modify-write of the column word
    assign word  = fwd_reg ? fwd_word_reg : rdata_reg;
    assign top   = b_top_ok_reg ? word[b_par_reg] : b_bg_reg;
    assign mid   = b_mid_ok_reg ? word[!b_par_reg] : b_bg_reg;
    assign wword = b_par_reg ? {b_v_reg, word[0]} : {word[1], b_v_reg};
    assign wen   = adv_b && b_store_reg;

    assign base = b_col0_reg ? {9{b_bg_reg}} : window_reg;
    assign w1   = b3le_pkg::win_shift(base, top, mid, b_v_reg);
    assign w2   = b3le_pkg::win_shift(w1, b_bg_reg, b_bg_reg, b_bg_reg);
    assign w3   = b3le_pkg::win_shift(w2, b_bg_reg, b_bg_reg, b_bg_reg);

    always_comb
    begin
        window_next = window_reg;
        if (adv_b)
        begin
            if (b_last_reg)
            begin
                window_next = '0;
            end
            else if (b_endr_reg)
            begin
                window_next = w3;
            end
            else
            begin
                window_next = w1;
            end
        end
    end

    assign win_valid     = b_valid_reg;
    assign win.idx0      = w1;
    assign win.idx1      = w2;
    assign win.idx2      = w3;
    assign win.row_end   = b_endr_reg;
    assign win.frame_end = b_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            fw_reg      <= '0;
            rows_reg    <= 2'd0;
            par_reg     <= 1'b0;
            bg_reg      <= 1'b0;
            b_valid_reg <= 1'b0;
            window_reg  <= '0;
        end
        else
        begin
            col_reg     <= col_next;
            fw_reg      <= fw_next;
            rows_reg    <= rows_next;
            par_reg     <= par_next;
            bg_reg      <= bg_next;
            b_valid_reg <= b_valid_next;
            window_reg  <= window_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            b_v_reg      <= v;
            b_endr_reg   <= endr;
            b_last_reg   <= last;
            b_bg_reg     <= bg_reg;
            b_col0_reg   <= (col_reg == '0);
            b_top_ok_reg <= in_frame && (rows_reg == 2'd2);
            b_mid_ok_reg <= in_frame && (rows_reg != 2'd0);
            b_par_reg    <= par_reg;
            b_store_reg  <= store;
            b_addr_reg   <= addr;
            // the write below lands on the same edge as this read
            fwd_reg      <= wen && (b_addr_reg == addr);
            fwd_word_reg <= wword;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc && store)
        begin
            rdata_reg <= mem[addr];
        end
        if (wen)
        begin
            mem[b_addr_reg] <= wword;
        end
    end

endmodule

// ----- rtl/b3le_emit.sv -----
module b3le_emit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [b3le_pkg::TABLE_SIZE-1:0] lut,
    input  logic                          win_valid,
    output logic                          win_ready,
    input  b3le_pkg::win_t                win,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          out_pixel,
    output logic                          out_end_of_row,
    output logic                          end_of_frame,
    output logic [b3le_pkg::LIT_W-1:0]    lit_count
);

    logic                       c_valid_reg, c_valid_next;
    logic [1:0]                 k_reg, k_next;
    b3le_pkg::win_t             slot_reg;
    logic                       o_valid_reg, o_valid_next;
    logic                       o_pixel_reg, o_eor_reg, o_eof_reg;
    logic [b3le_pkg::LIT_W-1:0] o_lit_reg;
    logic [b3le_pkg::LIT_W-1:0] lit_reg, lit_next;

    logic                       out_load, c_fire, c_done, take;
    logic [8:0]                 sel;
    logic                       p, eor, eof;
    logic [b3le_pkg::LIT_W-1:0] sum;

    assign out_load  = !o_valid_reg || out_ready;
    assign c_fire    = c_valid_reg && out_load;
    assign eor       = slot_reg.row_end && (k_reg == 2'd2);
    assign eof       = eor && slot_reg.frame_end;
    assign c_done    = c_fire && (!slot_reg.row_end || (k_reg == 2'd2));
    assign win_ready = !c_valid_reg || c_done;
    assign take      = win_valid && win_ready;

    always_comb
    begin
        unique case (k_reg)
            2'd0:    sel = slot_reg.idx0;
            2'd1:    sel = slot_reg.idx1;
            default: sel = slot_reg.idx2;
        endcase
    end

    assign p   = lut[sel];
    assign sum = (p && (lit_reg != b3le_pkg::LIT_CAP)) ? lit_reg + 1'b1 : lit_reg;

    always_comb
    begin
        c_valid_next = c_valid_reg;
        k_next       = k_reg;
        lit_next     = lit_reg;
        o_valid_next = o_valid_reg;
        if (out_load)
        begin
            o_valid_next = c_valid_reg;
        end
        if (c_fire)
        begin
            lit_next = eof ? '0 : sum;
            k_next   = k_reg + 2'd1;
        end
        if (take)
        begin
            c_valid_next = 1'b1;
            k_next       = 2'd0;
        end
        else if (c_done)
        begin
            c_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            k_reg       <= 2'd0;
            lit_reg     <= '0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            c_valid_reg <= c_valid_next;
            k_reg       <= k_next;
            lit_reg     <= lit_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            slot_reg <= win;
        end
        if (c_fire)
        begin
            o_pixel_reg <= p;
            o_eor_reg   <= eor;
            o_eof_reg   <= eof;
            o_lit_reg   <= sum;
        end
    end

    assign out_valid      = o_valid_reg;
    assign out_pixel      = o_pixel_reg;
    assign out_end_of_row = o_eor_reg;
    assign end_of_frame   = o_eof_reg;
    assign lit_count      = o_lit_reg;

endmodule

// ----- rtl/binary_3x3_lookup_enhance.sv -----
// Binary 3x3 lookup enhancement, one pass over a raster-order binary image.
// Input stream: one pixel per request; tuser selects image pixel or padding,
// tdata carries the pixel and the row-end mark, tlast closes the frame.
// Send H rows of W pixels, then two rows of W padding requests.
// Output stream: one enhanced pixel per request (three at row end), W+2 per row,
// H+2 rows; tlast marks the final pixel of the frame, tdata also carries the
// running saturating count of lit pixels.
// The 512-entry table is loaded through cfg_wen/cfg_index/cfg_data, eight
// 64-bit words, only while the stream is idle; the user, not the block, must ensure it.
// Each request passes the second stage, the emit slot and the output register.
// Throughput: one request per cycle while m_axis_tready is high; a row-end
// request gives three results and holds tready low while the single output port emits them.
// The line store is a MAX_WIDTH x 2-bit memory, one read and one write per
// cycle, read on acceptance, written back from the second stage with forwarding.
// Reset clears counters, window, background (dark), table and lit count.
// When m_axis_tready is low the output register holds and the pipeline stops,
// lowering s_axis_tready once the internal stages are full.
module binary_3x3_lookup_enhance #(
    parameter int MAX_WIDTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // pixel, end_of_row, zero fill
    input  logic [0:0]  s_axis_tuser,   // opcode
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // out_pixel, out_end_of_row, lit_count[16:0], zero fill
    output logic        m_axis_tlast,
    input  logic        cfg_wen,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic [b3le_pkg::TABLE_WORDS-1:0][63:0] table_reg;
    logic [b3le_pkg::TABLE_SIZE-1:0]         lut;

    logic                       win_valid, win_ready;
    b3le_pkg::win_t             win;
    logic                       out_pixel, out_end_of_row;
    logic [b3le_pkg::LIT_W-1:0] lit_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_reg <= '0;
        end
        else if (cfg_wen)
        begin
            table_reg[cfg_index] <= cfg_data;
        end
    end

    assign lut = table_reg;

    b3le_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .opcode     (s_axis_tuser[0]),
        .pixel      (s_axis_tdata[0]),
        .end_of_row (s_axis_tdata[1]),
        .last       (s_axis_tlast),
        .tbl_first  (lut[0]),
        .tbl_final  (lut[b3le_pkg::TABLE_SIZE-1]),
        .win_valid  (win_valid),
        .win_ready  (win_ready),
        .win        (win)
    );

    b3le_emit u_emit (
        .clk            (clk),
        .rst_n          (rst_n),
        .lut            (lut),
        .win_valid      (win_valid),
        .win_ready      (win_ready),
        .win            (win),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_pixel      (out_pixel),
        .out_end_of_row (out_end_of_row),
        .end_of_frame   (m_axis_tlast),
        .lit_count      (lit_count)
    );

    assign m_axis_tdata = {5'b0, lit_count, out_end_of_row, out_pixel};

endmodule
